// File: hdl/b64lw_pkg.sv
// ============================================================================
// b64lw_pkg
// Shared types, constants and the alphabet lookup for the line-wrapped
// base64 encoder.
// ============================================================================
package b64lw_pkg;

    localparam int unsigned JOB_CHARS       = 5;
    localparam int unsigned JOB_IDX_W       = $clog2(JOB_CHARS);
    localparam int unsigned QUEUE_DEPTH_DEF = 2;
    localparam logic [7:0]  WRAP_LIMIT_RST  = 8'd72;
    localparam logic [7:0]  CHAR_NEWLINE    = 8'h0A;
    localparam logic [7:0]  CHAR_PAD        = 8'h3D;
    localparam logic [7:0]  CHAR_PLUS       = 8'h2B;
    localparam logic [7:0]  CHAR_SLASH      = 8'h2F;
    localparam logic [7:0]  CHAR_UPPER_A    = 8'h41;
    localparam logic [7:0]  CHAR_LOWER_A    = 8'h61;
    localparam logic [7:0]  CHAR_DIGIT_0    = 8'h30;

    // One queued group of output characters, sent in order from index 0.
    typedef struct packed {
        logic [JOB_CHARS-1:0][7:0] chars;
        logic [JOB_IDX_W-1:0]      last_idx;
        logic                      is_last;
    } t_job;

    function automatic logic [7:0] enc_char(input logic [5:0] sym);
        logic [7:0] v_sym;
        v_sym = {2'b00, sym};
        case (sym) inside
            [6'd0:6'd25]:  enc_char = CHAR_UPPER_A + v_sym;
            [6'd26:6'd51]: enc_char = CHAR_LOWER_A + v_sym - 8'd26;
            [6'd52:6'd61]: enc_char = CHAR_DIGIT_0 + v_sym - 8'd52;
            6'd62:         enc_char = CHAR_PLUS;
            default:       enc_char = CHAR_SLASH;
        endcase
    endfunction

endpackage

// File: hdl/b64lw_front.sv
// ============================================================================
// b64lw_front
// Collects input bytes into groups, tracks the line length and the wrap
// limit, and pushes complete character groups to the queue.
// ============================================================================
module b64lw_front
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_final,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_wrap_limit,
    input  logic       i_queue_full,
    output logic       o_push,
    output t_job       o_job
);

    logic [7:0]  r_wrap_limit;
    logic [15:0] r_pend;
    logic [15:0] n_pend;
    logic [1:0]  r_pcount;
    logic [1:0]  n_pcount;
    logic [7:0]  r_line;
    logic [7:0]  n_line;
    logic        w_accept;
    logic [8:0]  w_next_line;
    logic        w_wrap;
    logic [7:0]  w_b0;
    logic [7:0]  w_b1;

    assign o_ready     = !i_queue_full;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_valid && o_ready;
    assign w_b0        = r_pend[15:8];
    assign w_b1        = r_pend[7:0];
    assign w_next_line = {1'b0, r_line} + 9'd4;
    assign w_wrap      = (w_next_line >= {1'b0, r_wrap_limit}) || w_next_line[8];

    always_comb begin
        n_pend   = r_pend;
        n_pcount = r_pcount;
        n_line   = r_line;
        o_push   = 1'b0;
        o_job    = '0;
        o_job.is_last = i_is_final;
        if (r_pcount == 2'd2) begin
            o_job.chars[0] = enc_char(w_b0[7:2]);
            o_job.chars[1] = enc_char({w_b0[1:0], w_b1[7:4]});
            o_job.chars[2] = enc_char({w_b1[3:0], i_data_byte[7:6]});
            o_job.chars[3] = enc_char(i_data_byte[5:0]);
            o_job.chars[4] = CHAR_NEWLINE;
            o_job.last_idx = (w_wrap || i_is_final) ? JOB_IDX_W'(4) : JOB_IDX_W'(3);
            o_push   = w_accept;
            n_pend   = '0;
            n_pcount = '0;
            n_line   = w_wrap ? 8'd0 : w_next_line[7:0];
        end else if (i_is_final) begin
            if (r_pcount == 2'd0) begin
                o_job.chars[0] = enc_char(i_data_byte[7:2]);
                o_job.chars[1] = enc_char({i_data_byte[1:0], 4'b0000});
                o_job.chars[2] = CHAR_PAD;
            end else begin
                o_job.chars[0] = enc_char(w_b0[7:2]);
                o_job.chars[1] = enc_char({w_b0[1:0], i_data_byte[7:4]});
                o_job.chars[2] = enc_char({i_data_byte[3:0], 2'b00});
            end
            o_job.chars[3] = CHAR_PAD;
            o_job.chars[4] = CHAR_NEWLINE;
            o_job.last_idx = JOB_IDX_W'(4);
            o_push = w_accept;
        end else begin
            if (r_pcount == 2'd0) begin
                n_pend = {i_data_byte, 8'h00};
            end else begin
                n_pend = {w_b0, i_data_byte};
            end
            n_pcount = r_pcount + 2'd1;
        end
        if (i_is_final) begin
            n_pend   = '0;
            n_pcount = '0;
            n_line   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_limit <= WRAP_LIMIT_RST;
            r_pend       <= '0;
            r_pcount     <= '0;
            r_line       <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_wrap_limit <= i_cfg_wrap_limit;
            end
            if (w_accept) begin
                r_pend   <= n_pend;
                r_pcount <= n_pcount;
                r_line   <= n_line;
            end
        end
    end

endmodule

// File: hdl/b64lw_queue.sv
// ============================================================================
// b64lw_queue
// Short first-in first-out queue of character groups between the front and
// back parts.
// ============================================================================
module b64lw_queue
    import b64lw_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_job o_job
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (w_pop && !w_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: hdl/b64lw_back.sv
// ============================================================================
// b64lw_back
// Takes character groups from the queue and sends them one character per
// word through a registered output stage.
// ============================================================================
module b64lw_back
    import b64lw_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_queue_empty,
    input  t_job       i_job,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_out_final
);

    t_job                 r_job;
    logic                 r_job_valid;
    logic [JOB_IDX_W-1:0] r_idx;
    logic                 r_out_valid;
    logic [7:0]           r_out_char;
    logic                 r_out_final;
    logic                 w_advance;
    logic                 w_job_done;

    assign w_advance   = r_job_valid && (!r_out_valid || i_ready);
    assign w_job_done  = w_advance && (r_idx == r_job.last_idx);
    assign o_pop       = !i_queue_empty && (!r_job_valid || w_job_done);
    assign o_valid     = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_final = r_out_final;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (w_advance) begin
            r_out_char  <= r_job.chars[r_idx];
            r_out_final <= r_job.is_last && (r_idx == r_job.last_idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job_valid <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_job_valid <= 1'b1;
                r_idx       <= '0;
            end else if (w_job_done) begin
                r_job_valid <= 1'b0;
                r_idx       <= '0;
            end else if (w_advance) begin
                r_idx <= r_idx + JOB_IDX_W'(1);
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

// File: hdl/base64_line_wrapped_encoder.sv
// ============================================================================
// base64_line_wrapped_encoder
// Base64 encoder with standard alphabet, '=' padding and line wrapping.
// ============================================================================
// Bytes enter one per word and characters leave one per word. A byte is
// accepted in any cycle in which the group queue has room; every third byte,
// and the final byte, loads a group of four or five characters into the
// queue. The output port sends one character per cycle while i_ready is
// held high, so the output port, not the input, sets the pace of a stream.
// The first character of a group passes through the queue memory, the job
// register and the output register before it appears. A new wrap limit
// applies from the next completed group and should be written only while no
// byte is in flight.
module base64_line_wrapped_encoder
    import b64lw_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_byte,
    input  logic       i_is_final,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_out_final,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_wrap_limit
);

    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_job w_job_in;
    t_job w_job_out;

    b64lw_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_is_final       (i_is_final),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_wrap_limit (i_cfg_wrap_limit),
        .i_queue_full     (w_full),
        .o_push           (w_push),
        .o_job            (w_job_in)
    );

    b64lw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_job   (w_job_out)
    );

    b64lw_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_queue_empty (w_empty),
        .i_job         (w_job_out),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_char    (o_out_char),
        .o_out_final   (o_out_final)
    );

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Checks the line-wrapped base64 encoder. Bytes go in as whole messages and
// every character that comes out is compared with a local model of the
// encoder that tracks the pending bytes and the line length, or with the
// text of a short table that covers the byte extremes, padding and the small
// and large wrap limits. Random messages follow under a range of wrap limits,
// with bursts of idle cycles on both sides.
// ============================================================================
module tb_top;
    import b64lw_pkg::*;

    localparam logic [0:63][7:0] B64_SYMBOLS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    localparam int unsigned DIR_ROWS = 24;
    localparam logic [0:6][7:0] PHASE_LIMITS =
        {8'd255, 8'd3, 8'd252, 8'd8, 8'd253, 8'd12, 8'd4};

    typedef struct packed {
        logic              set_cfg;
        logic [7:0]        cfg_val;
        logic [7:0]        data;
        logic              fin;
        logic              chk;
        logic [0:4][7:0]   txt;
    } t_dir_row;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
    } t_b64_char;

    localparam t_dir_row [0:DIR_ROWS-1] DIR_TABLE = {
        {1'b0, 8'd0,   8'h00, 1'b1, 1'b1, "AA==\n"},
        {1'b0, 8'd0,   8'hFF, 1'b1, 1'b1, "/w==\n"},
        {1'b0, 8'd0,   8'hFF, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'hFF, 1'b1, 1'b1, "//8=\n"},
        {1'b0, 8'd0,   8'h00, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h00, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h00, 1'b1, 1'b1, "AAAA\n"},
        {1'b0, 8'd0,   8'hFF, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'hFF, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'hFF, 1'b1, 1'b1, "////\n"},
        {1'b0, 8'd0,   8'h4D, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h61, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h6E, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h2E, 1'b1, 1'b0, 40'd0},
        {1'b1, 8'd4,   8'hFF, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'hFF, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'hFF, 1'b1, 1'b1, "////\n"},
        {1'b1, 8'd0,   8'h00, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h10, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h83, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h41, 1'b1, 1'b0, 40'd0},
        {1'b1, 8'd255, 8'h80, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h01, 1'b0, 1'b0, 40'd0},
        {1'b0, 8'd0,   8'h7F, 1'b1, 1'b0, 40'd0}
    };

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic       o_ready;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_is_final = 1'b0;
    logic       o_valid;
    logic       i_ready = 1'b0;
    logic [7:0] o_out_char;
    logic       o_out_final;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [7:0] i_cfg_wrap_limit = WRAP_LIMIT_RST;

    logic [15:0] pend_bytes;
    logic [1:0]  pend_cnt;
    logic [7:0]  line_cnt;
    logic [7:0]  wrap_lim;

    t_b64_char       step_chars[$];
    t_b64_char       exp_chars[$];
    logic            row_chk = 1'b0;
    logic [0:4][7:0] row_txt = '0;
    logic            idle_on = 1'b0;
    int unsigned     stall_left = 0;
    int unsigned     err_cnt = 0;

    base64_line_wrapped_encoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_is_final       (i_is_final),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_out_char       (o_out_char),
        .o_out_final      (o_out_final),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_wrap_limit (i_cfg_wrap_limit)
    );

    always #2 i_clk = ~i_clk;

    function void put_char(input logic [7:0] c);
        step_chars.push_back({c, 1'b0});
    endfunction

    function void put_sym(input logic [5:0] s);
        put_char(B64_SYMBOLS[s]);
    endfunction

    // Works out the characters that one accepted byte releases.
    function void encode_byte(input logic [7:0] b, input logic fin);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [8:0] next_len;
        t_b64_char  tail;
        b0 = pend_bytes[15:8];
        b1 = pend_bytes[7:0];
        step_chars.delete();
        if (pend_cnt == 2'd2) begin
            put_sym(b0[7:2]);
            put_sym({b0[1:0], b1[7:4]});
            put_sym({b1[3:0], b[7:6]});
            put_sym(b[5:0]);
            pend_bytes = '0;
            pend_cnt = '0;
            next_len = {1'b0, line_cnt} + 9'd4;
            if (next_len >= {1'b0, wrap_lim} || next_len > 9'd255) begin
                put_char(CHAR_NEWLINE);
                next_len = '0;
            end
            line_cnt = next_len[7:0];
            if (fin && line_cnt != 8'd0) begin
                put_char(CHAR_NEWLINE);
            end
        end else if (fin) begin
            if (pend_cnt == 2'd0) begin
                put_sym(b[7:2]);
                put_sym({b[1:0], 4'b0000});
                put_char(CHAR_PAD);
            end else begin
                put_sym(b0[7:2]);
                put_sym({b0[1:0], b[7:4]});
                put_sym({b[3:0], 2'b00});
            end
            put_char(CHAR_PAD);
            put_char(CHAR_NEWLINE);
        end else begin
            if (pend_cnt == 2'd0) begin
                pend_bytes = {b, 8'h00};
            end else begin
                pend_bytes = {b0, b};
            end
            pend_cnt = pend_cnt + 2'd1;
        end
        if (fin) begin
            if (step_chars.size() != 0) begin
                tail = step_chars.pop_back();
                tail.fin = 1'b1;
                step_chars.push_back(tail);
            end
            pend_bytes = '0;
            pend_cnt = '0;
            line_cnt = '0;
        end
    endfunction

    function void log_error(input string msg);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t ns: %s", $time, msg);
        end
    endfunction

    always @(posedge i_clk) begin
        t_b64_char got;
        t_b64_char want;
        if (!i_rst_n) begin
            wrap_lim = WRAP_LIMIT_RST;
            pend_bytes = '0;
            pend_cnt = '0;
            line_cnt = '0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_out_char, o_out_final};
                if (exp_chars.size() == 0) begin
                    log_error($sformatf("unexpected word: char %h final %b",
                                        o_out_char, o_out_final));
                end else begin
                    want = exp_chars.pop_front();
                    if (got != want) begin
                        log_error($sformatf("mismatch: expected char %h final %b, got char %h final %b",
                                            want.ch, want.fin, got.ch, got.fin));
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                wrap_lim = i_cfg_wrap_limit;
            end
            if (i_valid && o_ready) begin
                encode_byte(i_data_byte, i_is_final);
                if (row_chk) begin
                    for (int i = 0; i < 5; i++) begin
                        exp_chars.push_back({row_txt[i], i_is_final && i == 4});
                    end
                end else begin
                    foreach (step_chars[i]) begin
                        exp_chars.push_back(step_chars[i]);
                    end
                end
            end
        end
    end

    // Output side stalls in bursts at random.
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            i_ready = 1'b0;
        end else if (i_rst_n && idle_on && $urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_ready = 1'b0;
        end else begin
            i_ready = 1'b1;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic fin, input logic chk,
                             input logic [0:4][7:0] txt);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 7)) @(negedge i_clk);
        end
        row_chk = chk;
        row_txt = txt;
        i_valid = 1'b1;
        i_data_byte = b;
        i_is_final = fin;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
        i_valid = 1'b0;
        row_chk = 1'b0;
    endtask

    // The limit changes only between messages, once all output has drained.
    task automatic write_wrap_limit(input logic [7:0] v);
        while (exp_chars.size() != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_wrap_limit = v;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_message(input int unsigned len);
        logic [7:0] b;
        for (int unsigned k = 0; k < len; k++) begin
            case ($urandom_range(0, 7))
                0: b = 8'h00;
                1: b = 8'hFF;
                default: b = 8'($urandom_range(0, 255));
            endcase
            send_word(b, k == len - 1, 1'b0, '0);
        end
    endtask

    initial begin
        t_dir_row    r;
        logic [7:0]  lim;
        int unsigned sent;
        int unsigned len;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        idle_on = 1'b1;
        for (int k = 0; k < DIR_ROWS; k++) begin
            r = DIR_TABLE[k];
            if (r.set_cfg) begin
                write_wrap_limit(r.cfg_val);
            end
            send_word(r.data, r.fin, r.chk, r.txt);
        end

        for (int p = 0; p < 10; p++) begin
            lim = (p < 7) ? PHASE_LIMITS[p] : 8'($urandom_range(4, 40));
            write_wrap_limit(lim);
            if (p == 0) begin
                idle_on = 1'b1;
                send_message($urandom_range(193, 197));
            end else begin
                sent = 0;
                while (sent < 3) begin
                    idle_on = (p < 8) && ($urandom_range(0, 3) != 0);
                    len = ($urandom_range(0, 3) == 0) ? $urandom_range(7, 12)
                                                      : $urandom_range(1, 4);
                    send_message(len);
                    sent += len;
                end
            end
        end

        idle_on = 1'b0;
        while (exp_chars.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
